### hw/rtl/fro_pkg.sv
// Shared types, constants and helpers for the frame raster engine.
// No dependencies; every other file of the block but fro_ram uses this package.
package fro_pkg;

	// Frame store geometry. Pixels sit at row * MAX_WIDTH + column.
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int CW    = (XW > YW) ? XW : YW;
	localparam int AW    = XW + YW;
	localparam int DEPTH = MAX_HEIGHT << XW;

	localparam int RGBW = 24;
	localparam int IMGW = 7;
	localparam int CIW  = 3;

	// Request codes.
	localparam logic [2:0] REQ_WRITE  = 3'd0;
	localparam logic [2:0] REQ_READ   = 3'd1;
	localparam logic [2:0] REQ_CIRCLE = 3'd2;
	localparam logic [2:0] REQ_MIRROR = 3'd3;
	localparam logic [2:0] REQ_COPY   = 3'd4;

	// Status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_OOB   = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// Configuration register indexes.
	localparam logic [CIW-1:0] CFG_LINE_COLOR     = 3'd0;
	localparam logic [CIW-1:0] CFG_DISK_COLOR     = 3'd1;
	localparam logic [CIW-1:0] CFG_FILL_ENABLE    = 3'd2;
	localparam logic [CIW-1:0] CFG_RING_THICKNESS = 3'd3;
	localparam logic [CIW-1:0] CFG_FLIP_DIR       = 3'd4;
	localparam logic [CIW-1:0] CFG_IMAGE_WIDTH    = 3'd5;
	localparam logic [CIW-1:0] CFG_IMAGE_HEIGHT   = 3'd6;

	typedef struct packed {
		logic [2:0]        req_type;
		logic signed [7:0] x_a;
		logic signed [7:0] y_a;
		logic signed [7:0] x_b;
		logic signed [7:0] y_b;
		logic signed [7:0] dest_x;
		logic signed [7:0] dest_y;
		logic [7:0]        radius;
		logic [RGBW-1:0]   write_rgb;
	} in_t;

	typedef struct packed {
		logic [RGBW-1:0] read_rgb;
		logic [1:0]      status;
	} out_t;

	typedef struct packed {
		logic [RGBW-1:0] line_color;
		logic [RGBW-1:0] disk_color;
		logic            fill_enable;
		logic [7:0]      ring_thickness;
		logic            flip_dir;
		logic [IMGW-1:0] eff_w;
		logic [IMGW-1:0] eff_h;
	} cfg_t;

	typedef struct packed {
		logic            we;
		logic [AW-1:0]   waddr;
		logic [RGBW-1:0] wdata;
		logic [AW-1:0]   raddr;
	} ram_req_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_RD, S_CPREP, S_CMUL, S_CWR,
		S_MRA, S_MRB, S_MWA, S_MWB, S_KRD, S_KWR, S_PRD, S_PWR, S_FIN
	} fsm_state_t;

	// Word address of a pixel.
	function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
		pix_addr = {y[YW-1:0], x[XW-1:0]};
	endfunction

endpackage

### hw/rtl/frame_raster_ops_engine.sv
// Frame raster engine: a 64 x 64 RGB frame store with pixel write and read,
// circle draw, mirror and rectangle copy; one result transaction per request.
// Circle draw tests every pixel of the in-use image, mirror reads and then writes
// both pixels of each swapped pair, and copy first moves the source rectangle
// into the snapshot RAM and then writes it from there to the destination, each
// through the single read and single write port of its RAM. One request is in
// flight at a time; in_stall stays high until its result has moved to the output
// register, which then waits for the consumer while the next request is taken.
// The frame store has no reset and no clearing pass: pixels read before they are
// written return undefined data.
// Depends on fro_pkg, fro_cfg, fro_ctrl and fro_ram.
module frame_raster_ops_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  fro_pkg::in_t             in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output fro_pkg::out_t            out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [fro_pkg::CIW-1:0]  cfg_index,
	input  logic [fro_pkg::RGBW-1:0] cfg_data
);
	import fro_pkg::*;

	cfg_t            cfg;
	ram_req_t        frame_req, snap_req;
	logic [RGBW-1:0] frame_rdata, snap_rdata;

	// Configuration registers.
	fro_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Request sequencer.
	fro_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg         (cfg),
		.frame_req   (frame_req),
		.frame_rdata (frame_rdata),
		.snap_req    (snap_req),
		.snap_rdata  (snap_rdata)
	);

	// Frame store.
	fro_ram #(.WIDTH(RGBW), .DEPTH(DEPTH)) u_frame (
		.clk   (clk),
		.we    (frame_req.we),
		.waddr (frame_req.waddr),
		.wdata (frame_req.wdata),
		.raddr (frame_req.raddr),
		.rdata (frame_rdata)
	);

	// Copy source snapshot.
	fro_ram #(.WIDTH(RGBW), .DEPTH(DEPTH)) u_snap (
		.clk   (clk),
		.we    (snap_req.we),
		.waddr (snap_req.waddr),
		.wdata (snap_req.wdata),
		.raddr (snap_req.raddr),
		.rdata (snap_rdata)
	);

endmodule

### hw/rtl/fro_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module fro_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/fro_cfg.sv
// Configuration register file of the frame raster engine.
// Depends on fro_pkg for the register indexes and the cfg_t bundle.
module fro_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [fro_pkg::CIW-1:0]  cfg_index,
	input  logic [fro_pkg::RGBW-1:0] cfg_data,
	output fro_pkg::cfg_t          cfg
);
	import fro_pkg::*;

	logic [RGBW-1:0] line_color_q;
	logic [RGBW-1:0] disk_color_q;
	logic            fill_enable_q;
	logic [7:0]      ring_thickness_q;
	logic            flip_dir_q;
	logic [IMGW-1:0] image_width_q;
	logic [IMGW-1:0] image_height_q;

	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_color_q     <= '0;
			disk_color_q     <= '1;
			fill_enable_q    <= 1'b0;
			ring_thickness_q <= 8'd1;
			flip_dir_q       <= 1'b0;
			image_width_q    <= IMGW'(64);
			image_height_q   <= IMGW'(64);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LINE_COLOR:     line_color_q     <= cfg_data;
				CFG_DISK_COLOR:     disk_color_q     <= cfg_data;
				CFG_FILL_ENABLE:    fill_enable_q    <= cfg_data[0];
				CFG_RING_THICKNESS: ring_thickness_q <= cfg_data[7:0];
				CFG_FLIP_DIR:       flip_dir_q       <= cfg_data[0];
				CFG_IMAGE_WIDTH:    image_width_q    <= cfg_data[IMGW-1:0];
				CFG_IMAGE_HEIGHT:   image_height_q   <= cfg_data[IMGW-1:0];
				default: ;
			endcase
		end
	end

	// Image size clamped to the frame store.
	always_comb begin
		cfg.line_color     = line_color_q;
		cfg.disk_color     = disk_color_q;
		cfg.fill_enable    = fill_enable_q;
		cfg.ring_thickness = ring_thickness_q;
		cfg.flip_dir       = flip_dir_q;
		cfg.eff_w = (9'(image_width_q) > 9'(MAX_WIDTH)) ? IMGW'(MAX_WIDTH) : image_width_q;
		cfg.eff_h = (9'(image_height_q) > 9'(MAX_HEIGHT)) ? IMGW'(MAX_HEIGHT) : image_height_q;
	end

endmodule

### hw/rtl/fro_ctrl.sv
// Request sequencer: decodes each transaction, walks the frame store and snapshot
// RAMs for circle, mirror and copy, and holds the result register. Uses fro_pkg.
module fro_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  fro_pkg::in_t           in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output fro_pkg::out_t          out_data,
	input  fro_pkg::cfg_t          cfg,
	output fro_pkg::ram_req_t      frame_req,
	input  logic [fro_pkg::RGBW-1:0] frame_rdata,
	output fro_pkg::ram_req_t      snap_req,
	input  logic [fro_pkg::RGBW-1:0] snap_rdata
);
	import fro_pkg::*;

	fsm_state_t state_q, state_d;
	in_t  in_q;
	out_t res_q, out_q;
	logic out_valid_q;
	logic load;

	logic [CW-1:0]   ax_q, ay_q, bx_q, by_q, mid_q;
	logic [CW-1:0]   cwm1_q, chm1_q, dxc_q, dyc_q;
	logic [RGBW-1:0] tmp_q;
	logic [15:0]     r2_q, dx2_q, dy2_q;
	logic [17:0]     lo2_q;
	logic [19:0]     hi2_q;
	logic            lopos_q;

	function automatic logic in_rng(input logic signed [7:0] v, input logic [IMGW-1:0] lim);
		in_rng = !v[7] && ($unsigned(v) < {1'b0, lim});
	endfunction

	function automatic logic signed [11:0] sx12(input logic signed [7:0] v);
		sx12 = 12'(v);
	endfunction

	// Decode of the held transaction.
	logic xa_ok, ya_ok, xb_ok, yb_ok, pix_in, mir_ok, cpy_bad, cpy_empty;
	logic signed [11:0] cw0, ch0, xe, ye, cw1, ch1, cw2, ch2, w12, h12;
	logic [CW-1:0] l_c, u_c, r_c, d_c;
	logic [CW:0]   midx, midy;

	always_comb begin
		xa_ok  = in_rng(in_q.x_a, cfg.eff_w);
		ya_ok  = in_rng(in_q.y_a, cfg.eff_h);
		xb_ok  = in_rng(in_q.x_b, cfg.eff_w);
		yb_ok  = in_rng(in_q.y_b, cfg.eff_h);
		pix_in = xa_ok && ya_ok;
		mir_ok = xa_ok && ya_ok && xb_ok && yb_ok &&
			($unsigned(in_q.x_a) <= $unsigned(in_q.x_b)) &&
			($unsigned(in_q.y_a) <= $unsigned(in_q.y_b));
		cpy_bad = in_q.x_a[7] || in_q.y_a[7] ||
			(!in_q.x_b[7] && ($unsigned(in_q.x_b) >= {1'b0, cfg.eff_w})) ||
			(!in_q.y_b[7] && ($unsigned(in_q.y_b) >= {1'b0, cfg.eff_h}));
		w12 = $signed(12'(cfg.eff_w));
		h12 = $signed(12'(cfg.eff_h));
		cw0 = sx12(in_q.x_b) - sx12(in_q.x_a) + 12'sd1;
		ch0 = sx12(in_q.y_b) - sx12(in_q.y_a) + 12'sd1;
		xe  = sx12(in_q.dest_x) + cw0;
		ye  = sx12(in_q.dest_y) + ch0;
		cw1 = in_q.dest_x[7] ? cw0 + sx12(in_q.dest_x) : cw0;
		ch1 = in_q.dest_y[7] ? ch0 + sx12(in_q.dest_y) : ch0;
		cw2 = (xe > w12) ? cw1 - (xe - w12) : cw1;
		ch2 = (ye > h12) ? ch1 - (ye - h12) : ch1;
		cpy_empty = (cw2 <= 12'sd0) || (ch2 <= 12'sd0);
		l_c  = in_q.x_a[CW-1:0];
		u_c  = in_q.y_a[CW-1:0];
		r_c  = in_q.x_b[CW-1:0];
		d_c  = in_q.y_b[CW-1:0];
		midx = (CW+1)'(l_c) + (CW+1)'(r_c);
		midy = (CW+1)'(u_c) + (CW+1)'(d_c);
	end

	// Circle constants, computed once per command.
	logic signed [9:0] c_lo;
	logic [9:0]  c_hi;
	logic [15:0] r2_d;
	logic [17:0] lo2_d;
	logic [19:0] hi2_d;

	always_comb begin
		c_lo  = $signed({1'b0, in_q.radius, 1'b0}) - $signed({2'b00, cfg.ring_thickness});
		c_hi  = {1'b0, in_q.radius, 1'b0} + {2'b00, cfg.ring_thickness};
		r2_d  = 16'(in_q.radius) * 16'(in_q.radius);
		lo2_d = 18'(c_lo[8:0]) * 18'(c_lo[8:0]);
		hi2_d = 20'(c_hi) * 20'(c_hi);
	end

	// Per-pixel circle distance terms.
	logic signed [9:0]  cdx, cdy;
	logic signed [19:0] cdx2, cdy2;
	logic [16:0] d2;
	logic [18:0] d4;
	logic        fill_hit, ring_hit;

	always_comb begin
		cdx  = $signed(10'(ax_q)) - $signed(10'(in_q.x_a));
		cdy  = $signed(10'(ay_q)) - $signed(10'(in_q.y_a));
		cdx2 = cdx * cdx;
		cdy2 = cdy * cdy;
		d2   = 17'(dx2_q) + 17'(dy2_q);
		d4   = {d2, 2'b00};
		fill_hit = cfg.fill_enable && (d2 <= 17'(r2_q));
		ring_hit = (!lopos_q || (20'(d4) >= 20'(lo2_q))) && (20'(d4) <= hi2_q);
	end

	// Cursor end conditions.
	logic ix_last, iy_last, cx_last, cy_last, m_in_last, m_out_last;
	logic [AW-1:0] a_addr, b_addr, src_addr, dst_addr;

	always_comb begin
		ix_last = (ax_q == cwm1_q);
		iy_last = (ay_q == chm1_q);
		cx_last = (IMGW'(ax_q) == cfg.eff_w - IMGW'(1));
		cy_last = (IMGW'(ay_q) == cfg.eff_h - IMGW'(1));
		m_in_last  = cfg.flip_dir ? (ay_q == mid_q) : (ax_q == mid_q);
		m_out_last = cfg.flip_dir ? (ax_q == r_c) : (ay_q == d_c);
		a_addr   = pix_addr(ax_q, ay_q);
		b_addr   = pix_addr(bx_q, by_q);
		src_addr = pix_addr(l_c + ax_q, u_c + ay_q);
		dst_addr = pix_addr(dxc_q + ax_q, dyc_q + ay_q);
	end

	assign load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_DEC;
			S_DEC: begin
				case (in_q.req_type)
					REQ_READ:   state_d = pix_in ? S_RD : S_FIN;
					REQ_CIRCLE: state_d = (in_q.radius == 8'd0 || cfg.ring_thickness == 8'd0 ||
						cfg.eff_w == '0 || cfg.eff_h == '0) ? S_FIN : S_CPREP;
					REQ_MIRROR: state_d = mir_ok ? S_MRA : S_FIN;
					REQ_COPY:   state_d = (cpy_bad || cpy_empty) ? S_FIN : S_KRD;
					default:    state_d = S_FIN;
				endcase
			end
			S_RD:    state_d = S_FIN;
			S_CPREP: state_d = S_CMUL;
			S_CMUL:  state_d = S_CWR;
			S_CWR:   state_d = (cx_last && cy_last) ? S_FIN : S_CMUL;
			S_MRA:   state_d = S_MRB;
			S_MRB:   state_d = S_MWA;
			S_MWA:   state_d = S_MWB;
			S_MWB:   state_d = (m_in_last && m_out_last) ? S_FIN : S_MRA;
			S_KRD:   state_d = S_KWR;
			S_KWR:   state_d = (ix_last && iy_last) ? S_PRD : S_KRD;
			S_PRD:   state_d = S_PWR;
			S_PWR:   state_d = (ix_last && iy_last) ? S_FIN : S_PRD;
			S_FIN:   if (load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory requests and handshake outputs.
	always_comb begin
		frame_req = '0;
		snap_req  = '0;
		in_stall  = (state_q != S_IDLE);
		case (state_q)
			S_DEC: begin
				frame_req.raddr = pix_addr(l_c, u_c);
				frame_req.waddr = pix_addr(l_c, u_c);
				frame_req.wdata = in_q.write_rgb;
				frame_req.we    = (in_q.req_type == REQ_WRITE) && pix_in;
			end
			S_CWR: begin
				frame_req.we    = fill_hit || ring_hit;
				frame_req.waddr = a_addr;
				frame_req.wdata = ring_hit ? cfg.line_color : cfg.disk_color;
			end
			S_MRA: frame_req.raddr = a_addr;
			S_MRB: frame_req.raddr = b_addr;
			S_MWA: begin
				frame_req.we    = 1'b1;
				frame_req.waddr = a_addr;
				frame_req.wdata = frame_rdata;
			end
			S_MWB: begin
				frame_req.we    = 1'b1;
				frame_req.waddr = b_addr;
				frame_req.wdata = tmp_q;
			end
			S_KRD: frame_req.raddr = src_addr;
			S_KWR: begin
				snap_req.we    = 1'b1;
				snap_req.waddr = src_addr;
				snap_req.wdata = frame_rdata;
			end
			S_PRD: snap_req.raddr = src_addr;
			S_PWR: begin
				frame_req.we    = 1'b1;
				frame_req.waddr = dst_addr;
				frame_req.wdata = snap_rdata;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= load ? 1'b1 : (out_stall ? out_valid_q : 1'b0);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			in_q <= in_data;
		end
		if (load) begin
			out_q <= res_q;
		end
		case (state_q)
			S_DEC: begin
				res_q.read_rgb <= '0;
				case (in_q.req_type)
					REQ_WRITE, REQ_READ: res_q.status <= pix_in ? STAT_OK : STAT_OOB;
					REQ_MIRROR:          res_q.status <= mir_ok ? STAT_OK : STAT_OOB;
					REQ_COPY: res_q.status <= cpy_bad ? STAT_OOB :
						(cpy_empty ? STAT_EMPTY : STAT_OK);
					default:             res_q.status <= STAT_OK;
				endcase
				cwm1_q <= CW'(cw2 - 12'sd1);
				chm1_q <= CW'(ch2 - 12'sd1);
				dxc_q  <= in_q.dest_x[7] ? '0 : in_q.dest_x[CW-1:0];
				dyc_q  <= in_q.dest_y[7] ? '0 : in_q.dest_y[CW-1:0];
				if (in_q.req_type == REQ_MIRROR) begin
					ax_q <= l_c;
					ay_q <= u_c;
					if (cfg.flip_dir) begin
						bx_q  <= l_c;
						by_q  <= d_c;
						mid_q <= midy[CW:1];
					end else begin
						bx_q  <= r_c;
						by_q  <= u_c;
						mid_q <= midx[CW:1];
					end
				end else begin
					ax_q <= '0;
					ay_q <= '0;
				end
			end
			S_RD: res_q.read_rgb <= frame_rdata;
			S_CPREP: begin
				r2_q    <= r2_d;
				lo2_q   <= lo2_d;
				hi2_q   <= hi2_d;
				lopos_q <= !c_lo[9] && (c_lo != 10'sd0);
			end
			S_CMUL: begin
				dx2_q <= cdx2[15:0];
				dy2_q <= cdy2[15:0];
			end
			S_CWR: begin
				if (cx_last) begin
					ax_q <= '0;
					ay_q <= ay_q + CW'(1);
				end else begin
					ax_q <= ax_q + CW'(1);
				end
			end
			S_MRB: tmp_q <= frame_rdata;
			S_MWB: begin
				if (cfg.flip_dir) begin
					if (m_in_last) begin
						ay_q <= u_c;
						by_q <= d_c;
						ax_q <= ax_q + CW'(1);
						bx_q <= bx_q + CW'(1);
					end else begin
						ay_q <= ay_q + CW'(1);
						by_q <= by_q - CW'(1);
					end
				end else begin
					if (m_in_last) begin
						ax_q <= l_c;
						bx_q <= r_c;
						ay_q <= ay_q + CW'(1);
						by_q <= by_q + CW'(1);
					end else begin
						ax_q <= ax_q + CW'(1);
						bx_q <= bx_q - CW'(1);
					end
				end
			end
			S_KWR, S_PWR: begin
				if (ix_last) begin
					ax_q <= '0;
					ay_q <= iy_last ? '0 : ay_q + CW'(1);
				end else begin
					ax_q <= ax_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hw/rtl/fro_checker.sv
// Port-level checks for the frame raster engine, bound to the top level.
// Depends on fro_pkg and frame_raster_ops_engine.
module fro_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input fro_pkg::in_t             in_data,
	input logic                     out_valid,
	input logic                     out_stall,
	input fro_pkg::out_t            out_data,
	input logic                     cfg_valid,
	input logic                     cfg_ready,
	input logic [fro_pkg::CIW-1:0]  cfg_index,
	input logic [fro_pkg::RGBW-1:0] cfg_data
);
	import fro_pkg::*;

	// A stalled result transaction holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Only one request is worked on at a time.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	// Status codes stay in range.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_OOB ||
			out_data.status == STAT_EMPTY))
		else $error("bad status code");

	// Pixel data comes only with a good status.
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.read_rgb != '0) |-> out_data.status == STAT_OK)
		else $error("pixel data with error status");

endmodule

bind frame_raster_ops_engine fro_checker u_fro_checker (.*);

### dv/frame_raster_ops_engine_tb.sv
// Self-checking testbench for frame_raster_ops_engine: pixel, circle, mirror and copy requests
// are checked against a behavioral raster predictor or a fixed expectation, under random idling on both channels.
// Depends on fro_pkg and the engine RTL.
`timescale 1ns / 100ps

module frame_raster_ops_engine_tb;
	import fro_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CIW-1:0] cfg_index = '0;
	logic [RGBW-1:0] cfg_data = '0;

	frame_raster_ops_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the frame store and of the register file.
	logic [RGBW-1:0] shadow_px[DEPTH];
	logic [RGBW-1:0] snap_px[DEPTH];
	logic [RGBW-1:0] sh_line, sh_fill;
	logic sh_fen, sh_axis;
	logic [7:0] sh_thick;
	logic [IMGW-1:0] sh_w, sh_h;

	out_t pending_results[$];
	bit failed = 0;
	bit idle_on = 1;
	bit hold_off = 0;
	bit hold_done = 0;
	int quiet_cycles = 0;

	typedef struct {
		in_t req;
		bit typed;
		out_t want;
	} dir_row_t;

	// Clock.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int img_w();
		return (sh_w > MAX_WIDTH) ? MAX_WIDTH : int'(sh_w);
	endfunction

	function automatic int img_h();
		return (sh_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(sh_h);
	endfunction

	function automatic int px(int x, int y);
		return y * MAX_WIDTH + x;
	endfunction

	// Circle: interior fill, then the ring test on 4*d2.
	function automatic void paint_circle(int cx, int cy, longint r);
		longint t, lo, hi, ddx, ddy, d2;
		t = sh_thick;
		lo = 2 * r - t;
		hi = 2 * r + t;
		if (r == 0 || t == 0)
			return;
		for (int y = 0; y < img_h(); y++) begin
			for (int x = 0; x < img_w(); x++) begin
				ddx = x - cx;
				ddy = y - cy;
				d2 = ddx * ddx + ddy * ddy;
				if (sh_fen && d2 <= r * r)
					shadow_px[px(x, y)] = sh_fill;
				if ((lo <= 0 || 4 * d2 >= lo * lo) && 4 * d2 <= hi * hi)
					shadow_px[px(x, y)] = sh_line;
			end
		end
	endfunction

	function automatic logic [1:0] mirror_rect(int l, int u, int r, int d);
		logic [RGBW-1:0] t;
		int w, h;
		w = img_w();
		h = img_h();
		if (l < 0 || l >= w || u < 0 || u >= h || r < 0 || r >= w || d < 0 || d >= h ||
			l > r || u > d)
			return STAT_OOB;
		if (!sh_axis) begin
			for (int y = u; y <= d; y++)
				for (int x = l; x <= (l + r) / 2; x++) begin
					t = shadow_px[px(x, y)];
					shadow_px[px(x, y)] = shadow_px[px(r - (x - l), y)];
					shadow_px[px(r - (x - l), y)] = t;
				end
		end else begin
			for (int x = l; x <= r; x++)
				for (int y = u; y <= (u + d) / 2; y++) begin
					t = shadow_px[px(x, y)];
					shadow_px[px(x, y)] = shadow_px[px(x, d - (y - u))];
					shadow_px[px(x, d - (y - u))] = t;
				end
		end
		return STAT_OK;
	endfunction

	// Copy with clipping; the source origin is kept when the destination is clipped.
	function automatic logic [1:0] copy_rect(int l, int u, int r, int d, int ox, int oy);
		int w, h, cw, ch, xe, ye;
		w = img_w();
		h = img_h();
		if (l < 0 || u < 0 || r >= w || d >= h)
			return STAT_OOB;
		cw = r - l + 1;
		ch = d - u + 1;
		xe = ox + cw;
		ye = oy + ch;
		if (ox < 0) begin
			cw += ox;
			ox = 0;
		end
		if (oy < 0) begin
			ch += oy;
			oy = 0;
		end
		if (xe > w)
			cw -= xe - w;
		if (ye > h)
			ch -= ye - h;
		if (cw <= 0 || ch <= 0)
			return STAT_EMPTY;
		snap_px = shadow_px;
		for (int y = 0; y < ch; y++)
			for (int x = 0; x < cw; x++)
				shadow_px[px(ox + x, oy + y)] = snap_px[px(l + x, u + y)];
		return STAT_OK;
	endfunction

	function automatic out_t raster_predict(in_t q);
		out_t o;
		int xa, ya;
		bit on_img;
		xa = $signed(q.x_a);
		ya = $signed(q.y_a);
		o = '0;
		on_img = xa >= 0 && xa < img_w() && ya >= 0 && ya < img_h();
		case (q.req_type)
			REQ_WRITE: begin
				if (on_img) shadow_px[px(xa, ya)] = q.write_rgb;
				else o.status = STAT_OOB;
			end
			REQ_READ: begin
				if (on_img) o.read_rgb = shadow_px[px(xa, ya)];
				else o.status = STAT_OOB;
			end
			REQ_CIRCLE: paint_circle(xa, ya, longint'(q.radius));
			REQ_MIRROR: o.status = mirror_rect(xa, ya, $signed(q.x_b), $signed(q.y_b));
			REQ_COPY: o.status = copy_rect(xa, ya, $signed(q.x_b), $signed(q.y_b),
				$signed(q.dest_x), $signed(q.dest_y));
			default: ;
		endcase
		return o;
	endfunction

	// Offer one request transaction; the expectation is booked when it is taken.
	task automatic send_req(in_t q, bit typed, out_t want);
		out_t p;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= q;
		do @(posedge clk); while (in_stall);
		p = raster_predict(q);
		pending_results.push_back(typed ? want : p);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIW-1:0] idx, logic [RGBW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LINE_COLOR:     sh_line = val;
			CFG_DISK_COLOR:     sh_fill = val;
			CFG_FILL_ENABLE:    sh_fen = val[0];
			CFG_RING_THICKNESS: sh_thick = val[7:0];
			CFG_FLIP_DIR:       sh_axis = val[0];
			CFG_IMAGE_WIDTH:    sh_w = val[IMGW-1:0];
			CFG_IMAGE_HEIGHT:   sh_h = val[IMGW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [23:0] ln, logic [23:0] fl, logic fe, logic [7:0] th,
		logic ax, logic [6:0] w, logic [6:0] h);
		write_reg(CFG_LINE_COLOR, ln);
		write_reg(CFG_DISK_COLOR, fl);
		write_reg(CFG_FILL_ENABLE, {23'd0, fe});
		write_reg(CFG_RING_THICKNESS, {16'd0, th});
		write_reg(CFG_FLIP_DIR, {23'd0, ax});
		write_reg(CFG_IMAGE_WIDTH, {17'd0, w});
		write_reg(CFG_IMAGE_HEIGHT, {17'd0, h});
	endtask

	// Mostly a coordinate inside the image, sometimes any 8-bit value.
	function automatic logic [7:0] pick_coord(int lim);
		if (lim > 0 && $urandom_range(0, 99) < 85)
			return 8'($urandom_range(0, lim - 1));
		return 8'($urandom);
	endfunction

	function automatic in_t random_req();
		in_t q;
		int sel, w, h;
		w = img_w();
		h = img_h();
		q = in_t'($bits(in_t)'({$urandom, $urandom, $urandom}));
		sel = $urandom_range(0, 99);
		q.x_a = pick_coord(w);
		q.y_a = pick_coord(h);
		if (sel < 30) q.req_type = REQ_WRITE;
		else if (sel < 55) q.req_type = REQ_READ;
		else if (sel < 65) begin
			q.req_type = REQ_CIRCLE;
			if ($urandom_range(0, 9) != 0) q.radius = 8'($urandom_range(0, 20));
		end else if (sel < 80) begin
			q.req_type = REQ_MIRROR;
			if (w > 0 && $urandom_range(0, 9) != 0) begin
				q.x_b = 8'($signed(q.x_a) + $urandom_range(0, 6));
				q.y_b = 8'($signed(q.y_a) + $urandom_range(0, 6));
			end else begin
				q.x_b = pick_coord(w);
				q.y_b = pick_coord(h);
			end
		end else if (sel < 95) begin
			q.req_type = REQ_COPY;
			q.x_b = 8'($signed(q.x_a) + $urandom_range(0, 6));
			q.y_b = 8'($signed(q.y_a) + $urandom_range(0, 6));
			if ($urandom_range(0, 3) != 0) begin
				q.dest_x = 8'(int'($urandom_range(0, w + 8)) - 6);
				q.dest_y = 8'(int'($urandom_range(0, h + 8)) - 6);
			end
		end else
			q.req_type = 3'($urandom_range(5, 7));
		return q;
	endfunction

	function automatic in_t mk(logic [2:0] rt, int xa, int ya, int xb, int yb, int ox,
		int oy, int rad, logic [23:0] rgb);
		in_t q;
		q.req_type = rt;
		q.x_a = 8'(xa);
		q.y_a = 8'(ya);
		q.x_b = 8'(xb);
		q.y_b = 8'(yb);
		q.dest_x = 8'(ox);
		q.dest_y = 8'(oy);
		q.radius = 8'(rad);
		q.write_rgb = rgb;
		return q;
	endfunction

	// Result checker.
	always @(posedge clk) begin
		out_t w;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected");
				failed = 1;
			end else begin
				w = pending_results.pop_front();
				if (out_data.read_rgb !== w.read_rgb) begin
					$error("read_rgb expected %h actual %h", w.read_rgb, out_data.read_rgb);
					failed = 1;
				end
				if (out_data.status !== w.status) begin
					$error("status expected %0d actual %0d", w.status, out_data.status);
					failed = 1;
				end
			end
		end
	end

	// Output stall: random bursts, and one long hold-off when asked.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_off && !hold_done) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_done = 1;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		dir_row_t rows[$];
		out_t ok0, oob;
		ok0 = '0;
		oob = '0;
		oob.status = STAT_OOB;
		sh_line = '0;
		sh_fill = 24'hFFFFFF;
		sh_fen = 0;
		sh_thick = 8'd1;
		sh_axis = 0;
		sh_w = 7'd64;
		sh_h = 7'd64;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Cover the whole frame with one filled disk, then add a few smaller disks,
		// so that no later access reads an unwritten word.
		write_reg(CFG_FILL_ENABLE, 24'd1);
		for (int k = 0; k < 4; k++) begin
			write_reg(CFG_DISK_COLOR, 24'($urandom));
			send_req(mk(REQ_CIRCLE, (k == 0) ? 32 : int'($urandom_range(0, 63)),
				(k == 0) ? 32 : int'($urandom_range(0, 63)), 0, 0, 0, 0,
				(k == 0) ? 255 : int'($urandom_range(4, 20)), 0), 0, ok0);
			drain();
		end
		write_reg(CFG_FILL_ENABLE, 24'd0);
		write_reg(CFG_DISK_COLOR, 24'hFFFFFF);

		// Directed table: extremes, every request and the special cases.
		rows.push_back('{mk(REQ_WRITE, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF), 1, ok0});
		rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, out_t'({24'hFFFFFF, STAT_OK})});
		rows.push_back('{mk(REQ_WRITE, 63, 63, 0, 0, 0, 0, 0, 0), 1, ok0});
		rows.push_back('{mk(REQ_READ, 63, 63, 0, 0, 0, 0, 0, 24'hFFFFFF), 1, ok0});
		rows.push_back('{mk(REQ_WRITE, -1, 0, 0, 0, 0, 0, 0, 24'h123456), 1, oob});
		rows.push_back('{mk(REQ_READ, 64, 0, 0, 0, 0, 0, 0, 0), 1, oob});
		rows.push_back('{mk(REQ_READ, -128, 127, 0, 0, 0, 0, 0, 0), 1, oob});
		rows.push_back('{mk(REQ_READ, 127, -128, 0, 0, 0, 0, 0, 0), 1, oob});
		rows.push_back('{mk(REQ_CIRCLE, 10, 10, 0, 0, 0, 0, 0, 0), 1, ok0});
		rows.push_back('{mk(REQ_CIRCLE, 10, 10, 0, 0, 0, 0, 5, 0), 0, ok0});
		rows.push_back('{mk(REQ_CIRCLE, -3, 60, 0, 0, 0, 0, 8, 0), 0, ok0});
		rows.push_back('{mk(REQ_CIRCLE, -128, -128, 0, 0, 0, 0, 255, 0), 0, ok0});
		rows.push_back('{mk(REQ_MIRROR, 2, 3, 9, 7, 0, 0, 0, 0), 0, ok0});
		rows.push_back('{mk(REQ_MIRROR, 9, 3, 2, 7, 0, 0, 0, 0), 1, oob});
		rows.push_back('{mk(REQ_MIRROR, 0, 0, 64, 5, 0, 0, 0, 0), 1, oob});
		rows.push_back('{mk(REQ_COPY, -1, 0, 4, 4, 10, 10, 0, 0), 1, oob});
		rows.push_back('{mk(REQ_COPY, 0, 0, 4, 64, 10, 10, 0, 0), 1, oob});
		rows.push_back('{mk(REQ_COPY, 0, 0, 4, 4, 64, 0, 0, 0), 1, out_t'({24'd0, STAT_EMPTY})});
		rows.push_back('{mk(REQ_COPY, 0, 0, 4, 4, -5, 0, 0, 0), 1, out_t'({24'd0, STAT_EMPTY})});
		rows.push_back('{mk(REQ_COPY, 5, 5, 12, 9, -3, -2, 0, 0), 0, ok0});
		rows.push_back('{mk(REQ_COPY, 0, 0, 9, 9, 58, 60, 0, 0), 0, ok0});
		rows.push_back('{mk(REQ_COPY, 3, 3, 8, 8, 4, 4, 0, 0), 0, ok0});
		rows.push_back('{mk(5, 1, 1, 0, 0, 0, 0, 0, 0), 1, ok0});
		rows.push_back('{mk(7, -1, -1, -1, -1, -1, -1, 255, 24'hFFFFFF), 1, ok0});
		foreach (rows[i])
			send_req(rows[i].req, rows[i].typed, rows[i].want);
		drain();

		// Random phases under different register settings, extremes among them.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_regs(24'($urandom), 24'($urandom), 1'b1, 8'd3, 1'b0, 7'd16, 7'd12);
				1: set_regs(24'd0, 24'hFFFFFF, 1'b0, 8'd0, 1'b1, 7'd1, 7'd1);
				2: set_regs(24'hFFFFFF, 24'd0, 1'b1, 8'd255, 1'b1, 7'd64, 7'd64);
				3: set_regs(24'($urandom), 24'($urandom), 1'b1, 8'd2, 1'b0, 7'd0, 7'd127);
				4: set_regs(24'($urandom), 24'($urandom), 1'b1, 8'd9, 1'b1, 7'd127, 7'd5);
				default: set_regs(24'($urandom), 24'($urandom), 1'($urandom),
					8'($urandom_range(0, 12)), 1'($urandom),
					7'($urandom_range(1, 32)), 7'($urandom_range(1, 32)));
			endcase
			idle_on = (ph != 7);
			for (int n = 0; n < 100; n++) begin
				if (ph == 5 && n == 20) hold_off = 1;
				send_req(random_req(), 0, ok0);
			end
			drain();
		end

		if (!failed)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
